/* hw/rtl/fwe_pkg.sv */
// Shared types, constants and fixed-point helpers for the frustum edge generator.
// No dependencies; every other file imports this package.
package fwe_pkg;

    localparam int Q_W      = 32;   // coordinate width, signed Q16.16
    localparam int CFG_W    = 31;   // configuration register width
    localparam int FRAC_W   = 16;
    localparam int EDGE_W   = 4;
    localparam int NUM_EDGES = 12;
    localparam logic [EDGE_W-1:0] LAST_EDGE = EDGE_W'(NUM_EDGES - 1);

    localparam logic [CFG_W-1:0] TAN_HALF_FOV_RST  = 31'd65536;
    localparam logic [CFG_W-1:0] ASPECT_RATIO_RST  = 31'd65536;
    localparam logic [CFG_W-1:0] NEAR_DISTANCE_RST = 31'd6554;
    localparam logic [CFG_W-1:0] FAR_DISTANCE_RST  = 31'd6553600;

    typedef enum logic [1:0] {
        REG_TAN_HALF_FOV  = 2'd0,
        REG_ASPECT_RATIO  = 2'd1,
        REG_NEAR_DISTANCE = 2'd2,
        REG_FAR_DISTANCE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] tan_half_fov;
        logic [CFG_W-1:0] aspect_ratio;
        logic [CFG_W-1:0] near_distance;
        logic [CFG_W-1:0] far_distance;
    } cfg_t;

    typedef struct packed {
        logic signed [Q_W-1:0] eye_x;
        logic signed [Q_W-1:0] eye_y;
        logic signed [Q_W-1:0] eye_z;
        logic signed [Q_W-1:0] front_x;
        logic signed [Q_W-1:0] front_y;
        logic signed [Q_W-1:0] front_z;
        logic signed [Q_W-1:0] up_x;
        logic signed [Q_W-1:0] up_y;
        logic signed [Q_W-1:0] up_z;
        logic signed [Q_W-1:0] right_x;
        logic signed [Q_W-1:0] right_y;
        logic signed [Q_W-1:0] right_z;
    } cam_t;

    typedef struct packed {
        logic [EDGE_W-1:0]     edge_index;
        logic signed [Q_W-1:0] start_x;
        logic signed [Q_W-1:0] start_y;
        logic signed [Q_W-1:0] start_z;
        logic signed [Q_W-1:0] end_x;
        logic signed [Q_W-1:0] end_y;
        logic signed [Q_W-1:0] end_z;
        logic                  last_edge;
    } edge_t;

    // Sign-extend a coordinate to a 33-bit multiplier operand.
    function automatic logic signed [Q_W:0] s_ext(input logic signed [Q_W-1:0] x);
        return {x[Q_W-1], x};
    endfunction

    // Zero-extend a configuration value to a 33-bit multiplier operand.
    function automatic logic signed [Q_W:0] u_ext(input logic [CFG_W-1:0] x);
        return {2'b00, x};
    endfunction

    // Clamp to the signed range of sb bits.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [2*Q_W+1:0] v,
                                                   input int sb);
        logic signed [2*Q_W+1:0] hi;
        logic signed [2*Q_W+1:0] lo;
        hi = ((2*Q_W+2)'(1) <<< (sb - 1)) - (2*Q_W+2)'(1);
        lo = -hi - (2*Q_W+2)'(1);
        if (v > hi)
            return hi[Q_W-1:0];
        if (v < lo)
            return lo[Q_W-1:0];
        return v[Q_W-1:0];
    endfunction

    // Q16.16 product, floored, saturated.
    function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W:0] a,
                                                  input logic signed [Q_W:0] b,
                                                  input int sb);
        logic signed [2*Q_W+1:0] p;
        p = a * b;
        return sat_q(p >>> FRAC_W, sb);
    endfunction

    // Saturating add or subtract.
    function automatic logic signed [Q_W-1:0] qadd(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b,
                                                  input logic sub,
                                                  input int sb);
        logic signed [2*Q_W+1:0] ea;
        logic signed [2*Q_W+1:0] eb;
        ea = (2*Q_W+2)'(a);
        eb = (2*Q_W+2)'(b);
        return sat_q(sub ? ea - eb : ea + eb, sb);
    endfunction

    // Corner numbers at the two ends of an edge: {start, end}.
    function automatic logic [5:0] edge_ends(input logic [EDGE_W-1:0] e);
        logic [5:0] r;
        case (e)
            4'd0:    r = {3'd0, 3'd1};
            4'd1:    r = {3'd2, 3'd3};
            4'd2:    r = {3'd0, 3'd2};
            4'd3:    r = {3'd1, 3'd3};
            4'd4:    r = {3'd4, 3'd5};
            4'd5:    r = {3'd6, 3'd7};
            4'd6:    r = {3'd4, 3'd6};
            4'd7:    r = {3'd5, 3'd7};
            4'd8:    r = {3'd0, 3'd4};
            4'd9:    r = {3'd1, 3'd5};
            4'd10:   r = {3'd2, 3'd6};
            4'd11:   r = {3'd3, 3'd7};
            default: r = {3'd0, 3'd0};
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/fwe_cam_if.sv */
// Camera input channel: valid/ready handshake with one camera item as payload.
// Depends on fwe_pkg.
interface fwe_cam_if
    import fwe_pkg::*;
;
    logic valid;
    logic ready;
    cam_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/fwe_edge_if.sv */
// Edge result channel: valid/ready handshake with one frustum edge as payload.
// Depends on fwe_pkg.
interface fwe_edge_if
    import fwe_pkg::*;
;
    logic valid;
    logic ready;
    edge_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/fwe_cfg_regs.sv */
// Configuration register file: four write-only unsigned Q15.16 registers.
// Depends on fwe_pkg.
module fwe_cfg_regs
    import fwe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_TAN_HALF_FOV:  cfg_next.tan_half_fov  = cfg_wdata;
                REG_ASPECT_RATIO:  cfg_next.aspect_ratio  = cfg_wdata;
                REG_NEAR_DISTANCE: cfg_next.near_distance = cfg_wdata;
                REG_FAR_DISTANCE:  cfg_next.far_distance  = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tan_half_fov  <= TAN_HALF_FOV_RST;
            cfg_reg.aspect_ratio  <= ASPECT_RATIO_RST;
            cfg_reg.near_distance <= NEAR_DISTANCE_RST;
            cfg_reg.far_distance  <= FAR_DISTANCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/fwe_corner_pipe.sv */
// Three-stage corner pipeline: plane extents and offsets, centers, edge midpoints, then corners.
// Depends on fwe_pkg and fwe_cam_if; feeds fwe_edge_ser.
module fwe_corner_pipe
    import fwe_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    fwe_cam_if.sink               camera,
    output logic                  corner_valid,
    input  logic                  corner_ready,
    output logic signed [Q_W-1:0] corner [8][3]
);

    localparam int SAT_BITS = (COORD_WIDTH > Q_W) ? Q_W :
                              ((COORD_WIDTH < 16) ? 16 : COORD_WIDTH);

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    // stage 1: half heights, forward offsets
    logic signed [Q_W-1:0] h_reg     [2];
    logic signed [Q_W-1:0] fd_reg    [2][3];
    logic signed [Q_W-1:0] eye_reg   [3];
    logic signed [Q_W-1:0] up1_reg   [3];
    logic signed [Q_W-1:0] right1_reg[3];
    // stage 2: half widths, centers, up offsets
    logic signed [Q_W-1:0] w_reg     [2];
    logic signed [Q_W-1:0] ctr_reg   [2][3];
    logic signed [Q_W-1:0] uh_reg    [2][3];
    logic signed [Q_W-1:0] right2_reg[3];
    // stage 3: top and bottom edge midpoints, right offsets
    logic signed [Q_W-1:0] top_reg   [2][3];
    logic signed [Q_W-1:0] bot_reg   [2][3];
    logic signed [Q_W-1:0] rw_reg    [2][3];

    logic signed [Q_W-1:0] cam_vec   [4][3];
    logic [CFG_W-1:0]      plane_dist[2];

    assign adv3 = !v3_reg || corner_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign camera.ready = adv1;
    assign corner_valid = v3_reg;

    assign cam_vec[0] = '{camera.payload.eye_x,   camera.payload.eye_y,   camera.payload.eye_z};
    assign cam_vec[1] = '{camera.payload.front_x, camera.payload.front_y,
                          camera.payload.front_z};
    assign cam_vec[2] = '{camera.payload.up_x,    camera.payload.up_y,    camera.payload.up_z};
    assign cam_vec[3] = '{camera.payload.right_x, camera.payload.right_y,
                          camera.payload.right_z};

    assign plane_dist[0] = cfg.near_distance;
    assign plane_dist[1] = cfg.far_distance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= camera.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            for (int p = 0; p < 2; p++)
            begin
                h_reg[p] <= qmul(u_ext(cfg.tan_half_fov), u_ext(plane_dist[p]), SAT_BITS);
                for (int k = 0; k < 3; k++)
                    fd_reg[p][k] <= qmul(s_ext(cam_vec[1][k]), u_ext(plane_dist[p]),
                                         SAT_BITS);
            end
            for (int k = 0; k < 3; k++)
            begin
                eye_reg[k]    <= cam_vec[0][k];
                up1_reg[k]    <= cam_vec[2][k];
                right1_reg[k] <= cam_vec[3][k];
            end
        end
        if (adv2)
        begin
            for (int p = 0; p < 2; p++)
            begin
                w_reg[p] <= qmul(s_ext(h_reg[p]), u_ext(cfg.aspect_ratio), SAT_BITS);
                for (int k = 0; k < 3; k++)
                begin
                    ctr_reg[p][k] <= qadd(eye_reg[k], fd_reg[p][k], 1'b0, SAT_BITS);
                    uh_reg[p][k]  <= qmul(s_ext(up1_reg[k]), s_ext(h_reg[p]), SAT_BITS);
                end
            end
            for (int k = 0; k < 3; k++)
                right2_reg[k] <= right1_reg[k];
        end
        if (adv3)
        begin
            for (int p = 0; p < 2; p++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    top_reg[p][k] <= qadd(ctr_reg[p][k], uh_reg[p][k], 1'b0, SAT_BITS);
                    bot_reg[p][k] <= qadd(ctr_reg[p][k], uh_reg[p][k], 1'b1, SAT_BITS);
                    rw_reg[p][k]  <= qmul(s_ext(right2_reg[k]), s_ext(w_reg[p]), SAT_BITS);
                end
            end
        end
    end

    // Corner c = plane*4 + {bottom, right}: subtract the right offset on the left side.
    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                corner[c][k] = qadd(c[1] ? bot_reg[c/4][k] : top_reg[c/4][k],
                                    rw_reg[c/4][k], !c[0], SAT_BITS);
            end
        end
    end

endmodule

/* hw/rtl/fwe_edge_ser.sv */
// Edge serializer: holds the eight corners of one item and sends its edges one at a time.
// Depends on fwe_pkg and fwe_edge_if; fed by fwe_corner_pipe.
module fwe_edge_ser
    import fwe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  corner_valid,
    output logic                  corner_ready,
    input  logic signed [Q_W-1:0] corner [8][3],
    fwe_edge_if.source            edges
);

    logic                  busy_reg, busy_next;
    logic [EDGE_W-1:0]     cnt_reg, cnt_next;
    logic signed [Q_W-1:0] crn_reg [8][3];
    logic                  out_fire;
    logic                  finishing;
    logic                  load;
    logic [5:0]            ends;
    logic [2:0]            a_idx;
    logic [2:0]            b_idx;

    assign out_fire     = busy_reg && edges.ready;
    assign finishing    = out_fire && (cnt_reg == LAST_EDGE);
    assign corner_ready = !busy_reg || finishing;
    assign load         = corner_valid && corner_ready;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (finishing)
        begin
            busy_next = 1'b0;
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg + EDGE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            crn_reg <= corner;
    end

    assign ends  = edge_ends(cnt_reg);
    assign a_idx = ends[5:3];
    assign b_idx = ends[2:0];

    assign edges.valid              = busy_reg;
    assign edges.payload.edge_index = cnt_reg;
    assign edges.payload.start_x    = crn_reg[a_idx][0];
    assign edges.payload.start_y    = crn_reg[a_idx][1];
    assign edges.payload.start_z    = crn_reg[a_idx][2];
    assign edges.payload.end_x      = crn_reg[b_idx][0];
    assign edges.payload.end_y      = crn_reg[b_idx][1];
    assign edges.payload.end_z      = crn_reg[b_idx][2];
    assign edges.payload.last_edge  = (cnt_reg == LAST_EDGE);

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= LAST_EDGE))
        else $error("edge counter beyond last edge");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!busy_reg || finishing))
        else $error("corners loaded over an unfinished item");

    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (finishing && !corner_valid) |=> !busy_reg)
        else $error("serializer still busy after last edge");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !edges.ready) |=> (busy_reg && $stable(cnt_reg)))
        else $error("edge counter moved during stall");

    a_new_item_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (cnt_reg == '0))
        else $error("new item did not start at edge zero");
`endif

endmodule

/* hw/rtl/frustum_wireframe_edges_top.sv */
// Top level of the frustum edge generator: config registers, corner pipeline, serializer.
// Depends on fwe_pkg, fwe_cam_if, fwe_edge_if, fwe_cfg_regs, fwe_corner_pipe, fwe_edge_ser.
//
//   channel  | direction | payload             | handshake
//   ---------+-----------+---------------------+-----------------------------
//   camera   | in        | cam_t, 12 x Q16.16  | valid/ready
//   edges    | out       | edge_t, one edge    | valid/ready, 12 per camera item
//   cfg      | in        | 2-bit index, 31 bit | cfg_wr_en, no back-pressure
//
// Each camera item passes three register stages, then the serializer loads its corners;
// the first edge is valid once the corners are loaded, which waits for a free serializer.
// The edge port sends one edge per cycle unless edges.ready stalls it; up to three
// further items wait in the pipeline stages while the serializer drains the current item's edges.
// Reset restores the register defaults and empties all stages.
// A stall on the edge port holds the current edge and backs up the pipeline stage by
// stage; nothing is dropped or sent twice.
module frustum_wireframe_edges_top
    import fwe_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    fwe_cam_if.sink          camera,
    fwe_edge_if.source       edges,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cfg_t                  cfg;
    logic                  corner_valid;
    logic                  corner_ready;
    logic signed [Q_W-1:0] corner [8][3];

    fwe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fwe_corner_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .camera       (camera),
        .corner_valid (corner_valid),
        .corner_ready (corner_ready),
        .corner       (corner)
    );

    fwe_edge_ser u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .corner_valid (corner_valid),
        .corner_ready (corner_ready),
        .corner       (corner),
        .edges        (edges)
    );

endmodule

/* tb/tb_frustum_wireframe_edges_top.sv */
// Self-checking testbench for frustum_wireframe_edges_top: drives camera transactions,
// checks every edge transaction against a Q16.16 corner calculator kept in a small class.
// Depends on fwe_pkg, fwe_cam_if, fwe_edge_if and the RTL under hw/rtl.
module tb_frustum_wireframe_edges_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fwe_pkg::*;

    localparam int COORD_W       = 32;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int ONE           = 65536;
    localparam int Q_MAX         = 32'h7FFF_FFFF;
    localparam int Q_MIN         = int'(32'h8000_0000);

    // Expected edges of every accepted camera, oldest first, plus a shadow of the registers.
    class frustum_edge_ledger;
        cfg_t  regs;
        edge_t due[$];
        int    errors;
        int    sat_bits;

        function new(int coord_w);
            regs.tan_half_fov  = TAN_HALF_FOV_RST;
            regs.aspect_ratio  = ASPECT_RATIO_RST;
            regs.near_distance = NEAR_DISTANCE_RST;
            regs.far_distance  = FAR_DISTANCE_RST;
            errors = 0;
            sat_bits = (coord_w > 32) ? 32 : ((coord_w < 16) ? 16 : coord_w);
        endfunction

        function longint clamp(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (sat_bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        // Arithmetic shift floors toward minus infinity.
        function longint fix_mul(longint a, longint b);
            return clamp((a * b) >>> 16);
        endfunction

        function void note_camera(cam_t c);
            longint eye[3];
            longint fwd[3];
            longint upv[3];
            longint rgt[3];
            longint pt[8][3];
            longint plane_d;
            longint hh;
            longint hw;
            longint ctr;
            longint uh;
            longint rw;
            longint v;
            int     plane;
            int     k;
            int     n;
            int     e;
            int     a;
            int     b;
            int     j;
            edge_t  x;
            for (k = 0; k < 3; k++)
            begin
                eye[k] = longint'($signed(c[32*(11-k) +: 32]));
                fwd[k] = longint'($signed(c[32*(8-k) +: 32]));
                upv[k] = longint'($signed(c[32*(5-k) +: 32]));
                rgt[k] = longint'($signed(c[32*(2-k) +: 32]));
            end
            for (plane = 0; plane < 2; plane++)
            begin
                plane_d = (plane == 1) ? longint'(regs.far_distance)
                                       : longint'(regs.near_distance);
                hh = fix_mul(longint'(regs.tan_half_fov), plane_d);
                hw = fix_mul(hh, longint'(regs.aspect_ratio));
                for (k = 0; k < 3; k++)
                begin
                    ctr = clamp(eye[k] + fix_mul(fwd[k], plane_d));
                    uh = fix_mul(upv[k], hh);
                    rw = fix_mul(rgt[k], hw);
                    // corner bit 1 selects bottom, bit 0 selects right
                    for (n = 0; n < 4; n++)
                    begin
                        v = (n & 2) ? clamp(ctr - uh) : clamp(ctr + uh);
                        v = (n & 1) ? clamp(v + rw) : clamp(v - rw);
                        pt[plane*4 + n][k] = v;
                    end
                end
            end
            for (e = 0; e < NUM_EDGES; e++)
            begin
                // edges 0..7 are the near and far rectangles, 8..11 join near to far
                if (e < 8)
                begin
                    j = e % 4;
                    a = (e / 4) * 4 + ((j == 1) ? 2 : ((j == 3) ? 1 : 0));
                    b = (e / 4) * 4 + ((j == 0) ? 1 : ((j == 2) ? 2 : 3));
                end
                else
                begin
                    a = e - 8;
                    b = e - 4;
                end
                x.edge_index = EDGE_W'(e);
                x.start_x    = 32'(pt[a][0]);
                x.start_y    = 32'(pt[a][1]);
                x.start_z    = 32'(pt[a][2]);
                x.end_x      = 32'(pt[b][0]);
                x.end_y      = 32'(pt[b][1]);
                x.end_z      = 32'(pt[b][2]);
                x.last_edge  = (e == NUM_EDGES - 1);
                due = {due, x};
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task match_edge(edge_t got);
            edge_t want;
            if (due.size() == 0)
            begin
                report($sformatf("edge %0d with no camera pending", got.edge_index));
                return;
            end
            want = due.pop_front();
            check_field("edge_index", 32'(got.edge_index), 32'(want.edge_index));
            check_field("start_x", got.start_x, want.start_x);
            check_field("start_y", got.start_y, want.start_y);
            check_field("start_z", got.start_z, want.start_z);
            check_field("end_x", got.end_x, want.end_x);
            check_field("end_y", got.end_y, want.end_y);
            check_field("end_z", got.end_z, want.end_z);
            check_field("last_edge", 32'(got.last_edge), 32'(want.last_edge));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [1:0]       cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic             calm = 1'b0;
    int               calm_timer = 0;
    int               sink_hold = 0;
    int               quiet = 0;

    frustum_edge_ledger ledger = new(COORD_W);

    fwe_cam_if  cam_ch();
    fwe_edge_if edge_ch();

    frustum_wireframe_edges_top #(
        .COORD_WIDTH(COORD_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .camera    (cam_ch),
        .edges     (edge_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, a few long ones; none at all while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (calm_timer == 0)
        begin
            calm <= ($urandom_range(0, 4) == 0);
            calm_timer <= $urandom_range(50, 300);
        end
        else
            calm_timer <= calm_timer - 1;
    end

    // Edge sink: check each transaction, then stall at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            edge_ch.ready <= 1'b0;
        else
        begin
            if (edge_ch.valid && edge_ch.ready)
                ledger.match_edge(edge_ch.payload);
            if (sink_hold > 0)
            begin
                edge_ch.ready <= 1'b0;
                sink_hold--;
            end
            else
            begin
                edge_ch.ready <= 1'b1;
                sink_hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cam_ch.valid && cam_ch.ready) || (edge_ch.valid && edge_ch.ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic cam_t make_cam(int ex, int ey, int ez, int fx, int fy, int fz,
                                      int ux, int uy, int uz, int rx, int ry, int rz);
        return {ex, ey, ez, fx, fy, fz, ux, uy, uz, rx, ry, rz};
    endfunction

    function automatic int span(int r);
        return int'($urandom_range(0, 2*r)) - r;
    endfunction

    function automatic int extreme_word();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return Q_MAX;
            2:       return Q_MIN;
            3:       return -1;
            4:       return 1;
            5:       return ONE;
            6:       return -ONE;
            default: return int'($urandom);
        endcase
    endfunction

    // Mostly plausible cameras, then raw words, then corner values.
    function automatic cam_t random_camera();
        cam_t c;
        int   kind;
        int   i;
        kind = $urandom_range(0, 99);
        for (i = 0; i < 12; i++)
        begin
            if (kind < 60)
                c[32*(11-i) +: 32] = (i < 3) ? span(10000 * ONE) : span(ONE);
            else if (kind < 85)
                c[32*(11-i) +: 32] = $urandom;
            else
                c[32*(11-i) +: 32] = extreme_word();
        end
        return c;
    endfunction

    function automatic cfg_t random_config(bit wide);
        cfg_t c;
        if (wide)
        begin
            c.tan_half_fov  = CFG_W'($urandom);
            c.aspect_ratio  = CFG_W'($urandom);
            c.near_distance = CFG_W'($urandom);
            c.far_distance  = CFG_W'($urandom);
        end
        else
        begin
            c.tan_half_fov  = CFG_W'($urandom_range(0, 3 * ONE));
            c.aspect_ratio  = CFG_W'($urandom_range(ONE / 2, 3 * ONE));
            c.near_distance = CFG_W'($urandom_range(0, 4 * ONE));
            c.far_distance  = CFG_W'($urandom_range(0, 2000 * ONE));
        end
        return c;
    endfunction

    // Leave valid up after acceptance so back-to-back transactions need no toggle.
    task automatic send_camera(input cam_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cam_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cam_ch.valid <= 1'b1;
        cam_ch.payload <= c;
        @(posedge clk);
        while (!cam_ch.ready)
            @(posedge clk);
        ledger.note_camera(c);
    endtask

    task automatic drain_edges();
        cam_ch.valid <= 1'b0;
        @(posedge clk);
        while (ledger.due.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Only call with the block drained.
    task automatic load_config(input cfg_t c);
        put_reg(REG_TAN_HALF_FOV, c.tan_half_fov);
        put_reg(REG_ASPECT_RATIO, c.aspect_ratio);
        put_reg(REG_NEAR_DISTANCE, c.near_distance);
        put_reg(REG_FAR_DISTANCE, c.far_distance);
        cfg_wr_en <= 1'b0;
        ledger.regs = c;
    endtask

    task automatic send_random(input int count, input int pause_at);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (i == pause_at)
                drain_edges();
            send_camera(random_camera());
        end
    endtask

    initial
    begin
        cfg_t cfg;
        int   p;
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_addr       <= REG_TAN_HALF_FOV;
        cfg_wdata      <= '0;
        cam_ch.valid   <= 1'b0;
        cam_ch.payload <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values.
        send_camera(cam_t'('0));
        send_camera(cam_t'({12{Q_MAX}}));
        send_camera(cam_t'({12{Q_MIN}}));
        send_camera(cam_t'({12{32'hFFFF_FFFF}}));
        send_camera(cam_t'({12{32'h0000_0001}}));
        send_camera(make_cam(0, 0, 0, 0, 0, -ONE, 0, ONE, 0, ONE, 0, 0));
        send_camera(make_cam(10 * ONE, -5 * ONE, 3 * ONE + ONE / 2, -ONE, 0, 0,
                             0, 0, ONE, 0, ONE, 0));
        send_camera(make_cam(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                             Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_camera(make_cam(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                             Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        send_camera(cam_t'({6{32'h5555_5555, 32'hAAAA_AAAA}}));
        drain_edges();

        // Every register at its top value: saturation at each step.
        load_config(cfg_t'({4{31'h7FFF_FFFF}}));
        send_camera(cam_t'({12{Q_MAX}}));
        send_camera(cam_t'({12{Q_MIN}}));
        send_camera(make_cam(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                             Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        send_camera(make_cam(0, 0, 0, ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
        send_random(20, -1);
        drain_edges();

        // Every register zero: all corners collapse onto the eye.
        load_config(cfg_t'('0));
        send_camera(make_cam(0, 0, 0, 0, 0, -ONE, 0, ONE, 0, ONE, 0, 0));
        send_camera(cam_t'({12{Q_MAX}}));
        send_camera(cam_t'({12{32'hFFFF_FFFF}}));
        send_random(20, -1);
        drain_edges();

        // Far plane closer than near, with a full pause in the middle.
        cfg.tan_half_fov  = CFG_W'(ONE / 2);
        cfg.aspect_ratio  = CFG_W'(3 * ONE / 2);
        cfg.near_distance = CFG_W'(100 * ONE);
        cfg.far_distance  = CFG_W'(ONE);
        load_config(cfg);
        send_random(30, 15);
        drain_edges();

        for (p = 0; p < 6; p++)
        begin
            load_config(random_config(p % 2 == 0));
            send_random(29, -1);
            drain_edges();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ledger.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
